/* src/three_point_circle_center_macros.svh */
// Assertion macros shared by the circle center block.
`ifndef THREE_POINT_CIRCLE_CENTER_MACROS_SVH
`define THREE_POINT_CIRCLE_CENTER_MACROS_SVH
`ifndef ASSERT_OFF
// Check that cond_a implies cond_b in the same cycle.
`define TPC_ASSERT_IMPLY(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("tpc assertion failed");
// Check that cond_a implies cond_b in the next cycle.
`define TPC_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("tpc assertion failed");
`else
`define TPC_ASSERT_IMPLY(label, clk, rst_n, cond_a, cond_b)
`define TPC_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b)
`endif
`endif

/* src/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Widths, beat types and constants of the three point circle center block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CENTER_WIDTH = 32;

    // differences and pair sums of coordinates
    localparam int DIFF_W = COORD_WIDTH + 1;
    // products of two differences
    localparam int PROD_W = 2 * DIFF_W;
    // bisector constants and determinant
    localparam int E_W    = PROD_W + 1;
    // cross products of numerators
    localparam int MUL_W  = E_W + DIFF_W;
    // numerators
    localparam int NUM_W  = MUL_W + 1;
    // twice the determinant magnitude
    localparam int DEN_W  = E_W + 1;
    // width for the saturation compare
    localparam int CMP_W  = ((NUM_W > CENTER_WIDTH) ? NUM_W : CENTER_WIDTH) + 1;

    localparam logic [CMP_W-1:0] LIM_POS =
        CMP_W'((64'd1 << (CENTER_WIDTH - 1)) - 64'd1);
    localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(64'd1 << (CENTER_WIDTH - 1));

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] mid_x;
        logic signed [COORD_WIDTH-1:0] mid_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [CENTER_WIDTH-1:0] center_x;
        logic signed [CENTER_WIDTH-1:0] center_y;
        logic                           found;
        logic                           clipped;
    } out_beat_t;

    typedef struct packed {
        logic [NUM_W-1:0] mag_x;
        logic [NUM_W-1:0] mag_y;
        logic [DEN_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
    } div_in_t;

    typedef struct packed {
        logic [NUM_W-1:0] q_x;
        logic [NUM_W-1:0] q_y;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
    } div_out_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem_x;
        logic [DEN_W-1:0] rem_y;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [NUM_W-1:0] q_x;
        logic [NUM_W-1:0] q_y;
        logic [DEN_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
    } div_stage_t;

endpackage

`default_nettype wire

/* src/tpc_front.sv */
// ----------------------------------------------------------------------------
// tpc_front
// Five register stages that build the Cramer numerators and denominator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire tpc_pkg::in_beat_t in_beat,
    output logic                   out_valid,
    output tpc_pkg::div_in_t       out_beat
);

    localparam int CW = tpc_pkg::COORD_WIDTH;
    localparam int DW = tpc_pkg::DIFF_W;
    localparam int PW = tpc_pkg::PROD_W;
    localparam int EW = tpc_pkg::E_W;
    localparam int MW = tpc_pkg::MUL_W;
    localparam int NW = tpc_pkg::NUM_W;

    logic [4:0] vld_reg;

    // stage 1
    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg, pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [DW-1:0] sx, sy, mx, my, ex, ey;
    // stage 2
    logic signed [PW-1:0] m1_reg, m2_reg, m3_reg, m4_reg, ad_reg, bc_reg;
    logic signed [DW-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    // stage 3
    logic signed [EW-1:0] e1_reg, e2_reg, det_reg;
    logic signed [DW-1:0] a3_reg, b3_reg, c3_reg, d3_reg;
    // stage 4
    logic signed [MW-1:0] px1_reg, px2_reg, py1_reg, py2_reg;
    logic [EW-1:0]        dabs_reg;
    logic                 dneg_reg, zero_reg;
    // stage 5
    tpc_pkg::div_in_t     out_reg;
    logic signed [NW-1:0] nx, ny;

    assign sx = {in_beat.start_x[CW-1], in_beat.start_x};
    assign sy = {in_beat.start_y[CW-1], in_beat.start_y};
    assign mx = {in_beat.mid_x[CW-1], in_beat.mid_x};
    assign my = {in_beat.mid_y[CW-1], in_beat.mid_y};
    assign ex = {in_beat.end_x[CW-1], in_beat.end_x};
    assign ey = {in_beat.end_y[CW-1], in_beat.end_y};

    assign nx = NW'(px1_reg) - NW'(px2_reg);
    assign ny = NW'(py1_reg) - NW'(py2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= mx - sx;
            b_reg  <= my - sy;
            c_reg  <= ex - mx;
            d_reg  <= ey - my;
            pa_reg <= mx + sx;
            pb_reg <= my + sy;
            pc_reg <= ex + mx;
            pd_reg <= ey + my;

            m1_reg <= PW'(a_reg) * PW'(pa_reg);
            m2_reg <= PW'(b_reg) * PW'(pb_reg);
            m3_reg <= PW'(c_reg) * PW'(pc_reg);
            m4_reg <= PW'(d_reg) * PW'(pd_reg);
            ad_reg <= PW'(a_reg) * PW'(d_reg);
            bc_reg <= PW'(b_reg) * PW'(c_reg);
            a2_reg <= a_reg;
            b2_reg <= b_reg;
            c2_reg <= c_reg;
            d2_reg <= d_reg;

            e1_reg  <= EW'(m1_reg) + EW'(m2_reg);
            e2_reg  <= EW'(m3_reg) + EW'(m4_reg);
            det_reg <= EW'(ad_reg) - EW'(bc_reg);
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            c3_reg  <= c2_reg;
            d3_reg  <= d2_reg;

            px1_reg  <= MW'(e1_reg) * MW'(d3_reg);
            px2_reg  <= MW'(b3_reg) * MW'(e2_reg);
            py1_reg  <= MW'(a3_reg) * MW'(e2_reg);
            py2_reg  <= MW'(c3_reg) * MW'(e1_reg);
            dneg_reg <= det_reg[EW-1];
            dabs_reg <= det_reg[EW-1] ? EW'(-det_reg) : EW'(det_reg);
            zero_reg <= (det_reg == '0);

            out_reg.mag_x <= nx[NW-1] ? NW'(-nx) : NW'(nx);
            out_reg.mag_y <= ny[NW-1] ? NW'(-ny) : NW'(ny);
            out_reg.neg_x <= nx[NW-1] ^ dneg_reg;
            out_reg.neg_y <= ny[NW-1] ^ dneg_reg;
            out_reg.den   <= {dabs_reg, 1'b0};
            out_reg.zero  <= zero_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_beat  = out_reg;

endmodule

`default_nettype wire

/* src/tpc_div.sv */
// ----------------------------------------------------------------------------
// tpc_div
// Restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire tpc_pkg::div_in_t  in_beat,
    output logic                   out_valid,
    output tpc_pkg::div_out_t      out_beat
);

    localparam int NW = tpc_pkg::NUM_W;
    localparam int DNW = tpc_pkg::DEN_W;

    tpc_pkg::div_stage_t st_reg [NW];
    logic [NW-1:0]       vld_reg;
    tpc_pkg::div_stage_t src0;

    always_comb begin
        src0       = '0;
        src0.num_x = in_beat.mag_x;
        src0.num_y = in_beat.mag_y;
        src0.den   = in_beat.den;
        src0.neg_x = in_beat.neg_x;
        src0.neg_y = in_beat.neg_y;
        src0.zero  = in_beat.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        tpc_pkg::div_stage_t src, st_next;
        logic [DNW:0]        rin_x, rin_y;

        if (k == 0) begin : g_first
            assign src = src0;
        end else begin : g_rest
            assign src = st_reg[k-1];
        end

        always_comb begin
            st_next       = src;
            rin_x         = {src.rem_x, src.num_x[NW-1]};
            rin_y         = {src.rem_y, src.num_y[NW-1]};
            st_next.num_x = src.num_x << 1;
            st_next.num_y = src.num_y << 1;
            if (rin_x >= {1'b0, src.den}) begin
                st_next.rem_x = DNW'(rin_x - {1'b0, src.den});
                st_next.q_x   = {src.q_x[NW-2:0], 1'b1};
            end else begin
                st_next.rem_x = DNW'(rin_x);
                st_next.q_x   = {src.q_x[NW-2:0], 1'b0};
            end
            if (rin_y >= {1'b0, src.den}) begin
                st_next.rem_y = DNW'(rin_y - {1'b0, src.den});
                st_next.q_y   = {src.q_y[NW-2:0], 1'b1};
            end else begin
                st_next.rem_y = DNW'(rin_y);
                st_next.q_y   = {src.q_y[NW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_valid      = vld_reg[NW-1];
    assign out_beat.q_x   = st_reg[NW-1].q_x;
    assign out_beat.q_y   = st_reg[NW-1].q_y;
    assign out_beat.neg_x = st_reg[NW-1].neg_x;
    assign out_beat.neg_y = st_reg[NW-1].neg_y;
    assign out_beat.zero  = st_reg[NW-1].zero;

endmodule

`default_nettype wire

/* src/three_point_circle_center.sv */
// ----------------------------------------------------------------------------
// three_point_circle_center
// Circumcenter of three points by Cramer's rule, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one beat of three signed points per clock and returns one
// beat per input: the circle center through them, each coordinate the exact
// quotient truncated toward zero and saturated to the output width (clipped
// set when saturation happened). Collinear or coincident points give found
// low and an all-zero center. Five stages form the numerators and twice the
// determinant, the restoring divider spends one stage per quotient bit of the
// widest numerator, and one stage saturates into the output register.
// Throughput is one beat per cycle; the whole pipeline holds while a result
// waits on m_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "three_point_circle_center_macros.svh"

module three_point_circle_center (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tpc_pkg::in_beat_t  s_beat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tpc_pkg::out_beat_t      m_beat
);

    localparam int NW  = tpc_pkg::NUM_W;
    localparam int OW  = tpc_pkg::CENTER_WIDTH;
    localparam int CPW = tpc_pkg::CMP_W;

    // advance every stage together when the output slot is free or draining
    logic               en;
    logic               front_valid, div_valid;
    tpc_pkg::div_in_t   front_beat;
    tpc_pkg::div_out_t  div_beat;

    logic               out_valid_reg;
    tpc_pkg::out_beat_t out_reg, out_next;

    logic [CPW-1:0]     qx, qy, lim_x, lim_y, vx, vy;
    logic               sat_x, sat_y;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    tpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_beat   (s_beat),
        .out_valid (front_valid),
        .out_beat  (front_beat)
    );

    tpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_beat   (front_beat),
        .out_valid (div_valid),
        .out_beat  (div_beat)
    );

    // saturate each quotient magnitude against its signed bound, then apply sign
    always_comb begin
        qx    = CPW'(div_beat.q_x);
        qy    = CPW'(div_beat.q_y);
        lim_x = div_beat.neg_x ? tpc_pkg::LIM_NEG : tpc_pkg::LIM_POS;
        lim_y = div_beat.neg_y ? tpc_pkg::LIM_NEG : tpc_pkg::LIM_POS;
        sat_x = qx > lim_x;
        sat_y = qy > lim_y;
        vx    = sat_x ? lim_x : qx;
        vy    = sat_y ? lim_y : qy;
        if (div_beat.neg_x) begin
            vx = -vx;
        end
        if (div_beat.neg_y) begin
            vy = -vy;
        end
        if (div_beat.zero) begin
            // collinear points: drop the quotient
            out_next = '0;
        end else begin
            out_next.center_x = vx[OW-1:0];
            out_next.center_y = vy[OW-1:0];
            out_next.found    = 1'b1;
            out_next.clipped  = sat_x || sat_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_beat  = out_reg;

    // a collinear result carries nothing but zeros
    `TPC_ASSERT_IMPLY(a_zero_on_miss, aclk, aresetn, m_valid && !m_beat.found,
        m_beat.center_x == '0 && m_beat.center_y == '0 && !m_beat.clipped)
    // saturation only happens on a solved center
    `TPC_ASSERT_IMPLY(a_clip_found, aclk, aresetn, m_valid && m_beat.clipped, m_beat.found)
    // a held result keeps the whole pipeline frozen
    `TPC_ASSERT_NEXT(a_hold_div, aclk, aresetn, m_valid && !m_ready,
        div_valid == $past(div_valid))

endmodule

`default_nettype wire
